// ----- hw/rtl/bmh_pkg.sv -----
// package for the binary min-heap engine: beat types, opcodes, status codes
// and default sizes; depends on nothing
package bmh_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
    } req_t;

    typedef struct packed {
        logic [31:0] min_key;
        logic [1:0]  status;
    } rsp_t;

endpackage

// ----- hw/rtl/bmh_ram.sv -----
// generic single-write, single-read ram with registered read data
// used for the heap store; depends on nothing
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/binary_min_heap_engine_top.sv -----
// binary min-heap engine: opcode sequencer, sift-down datapath and result register
// depends on bmh_pkg and bmh_ram
//
// usage:
//   req channel (req_valid, req_stall, req) carries one beat per operation:
//   append a key at the end of the store, build the heap over the store, or
//   pop the minimum. rsp channel (rsp_valid, rsp_stall, rsp) returns exactly
//   one beat per request with the popped key and a status code.
//   one request is in work at a time; req_stall is low only while idle. the
//   result sits in an output register, so the next request is taken while an
//   earlier result still waits on a stalled rsp channel.
//   an append, an error or an unused opcode needs no sift-down;
//   a pop reads the root, then the last entry, then sifts that entry down from
//   the root; a build reads and sifts down each internal node from the last
//   one to the root. the sift-down pace is set by the single read port of the
//   store: two child reads per level.
//   reset empties the heap (count to zero) and drops any pending result; the
//   store contents are not cleared and need no clearing pass.
//   a stalled rsp holds its beat; the block waits with its next result until
//   the output register is free.
module binary_min_heap_engine_top
    import bmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = $clog2(CAPACITY > 1 ? CAPACITY : 2);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_POP1 = 9'b000000010,
        S_POP2 = 9'b000000100,
        S_BRD  = 9'b000001000,
        S_BLD  = 9'b000010000,
        S_SL   = 9'b000100000,
        S_SR   = 9'b001000000,
        S_SC   = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic [AW-1:0]       bidx_reg, bidx_next;
    logic [KEY_BITS-1:0] sift_reg, sift_next;
    logic [KEY_BITS-1:0] left_reg, left_next;
    logic [31:0]         min_reg, min_next;
    logic [1:0]          status_reg, status_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic [63:0]         key_wide;
    logic [KEY_BITS-1:0] key_in;
    logic [63:0]         rd_wide;
    logic [IW-1:0]       n_ext;
    logic [IW-1:0]       left_idx;
    logic [IW-1:0]       right_idx;
    logic                has_left;
    logic                has_right;
    logic                take_right;
    logic [AW-1:0]       pick_idx;
    logic [KEY_BITS-1:0] pick_val;
    logic [IW-1:0]       nleft_idx;
    logic                sift_end;

    assign key_wide  = {32'b0, req.key};
    assign key_in    = key_wide[KEY_BITS-1:0];
    assign rd_wide   = 64'(ram_rdata);
    assign n_ext     = IW'(count_reg);
    assign left_idx  = IW'({cur_reg, 1'b1});
    assign right_idx = left_idx + IW'(1);
    assign has_left  = left_idx < n_ext;
    assign has_right = right_idx < n_ext;
    assign take_right = has_right && !(left_reg < ram_rdata);
    assign pick_idx  = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign pick_val  = take_right ? ram_rdata : left_reg;
    assign nleft_idx = IW'({pick_idx, 1'b1});

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bmh_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        count_next     = count_reg;
        cur_next       = cur_reg;
        bidx_next      = bidx_reg;
        sift_next      = sift_reg;
        left_next      = left_reg;
        min_next       = min_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = sift_reg;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        sift_end       = 1'b0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req.opcode;
                    min_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_DONE;
                    case (req.opcode)
                        OP_APPEND:
                        begin
                            if (count_reg >= CW'(CAPACITY))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = AW'(count_reg);
                                ram_wdata  = key_in;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_BUILD:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                bidx_next  = AW'((count_reg >> 1) - CW'(1));
                                state_next = S_BRD;
                            end
                        end
                        OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                state_next = S_POP1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP1:
            begin
                min_next   = rd_wide[31:0];
                ram_re     = 1'b1;
                ram_raddr  = AW'(count_reg - CW'(1));
                count_next = count_reg - CW'(1);
                state_next = S_POP2;
            end
            S_POP2:
            begin
                sift_next = ram_rdata;
                cur_next  = '0;
                if (count_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SL;
                end
            end
            S_BRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = bidx_reg;
                state_next = S_BLD;
            end
            S_BLD:
            begin
                sift_next  = ram_rdata;
                cur_next   = bidx_reg;
                state_next = S_SL;
            end
            S_SL:
            begin
                if (has_left)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = left_idx[AW-1:0];
                    state_next = S_SR;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = sift_reg;
                    sift_end  = 1'b1;
                end
            end
            S_SR:
            begin
                left_next = ram_rdata;
                if (has_right)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = right_idx[AW-1:0];
                end
                state_next = S_SC;
            end
            S_SC:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                if (sift_reg > pick_val)
                begin
                    ram_wdata = pick_val;
                    cur_next  = pick_idx;
                    if (nleft_idx < n_ext)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = nleft_idx[AW-1:0];
                        state_next = S_SR;
                    end
                    else
                    begin
                        state_next = S_SL;
                    end
                end
                else
                begin
                    ram_wdata = sift_reg;
                    sift_end  = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_next.min_key = min_reg;
                    rsp_next.status  = status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (sift_end)
        begin
            if (op_reg == OP_BUILD && bidx_reg != '0)
            begin
                bidx_next  = bidx_reg - AW'(1);
                state_next = S_BRD;
            end
            else
            begin
                state_next = S_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cur_reg    <= cur_next;
        bidx_reg   <= bidx_next;
        sift_reg   <= sift_next;
        left_reg   <= left_next;
        min_reg    <= min_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    // store never sees a read and a write of the same entry in one cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("store read and write hit the same entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count beyond capacity");

    // a result beat appears only from the finishing state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat without a finished operation");

    // count moves only on an accepted append or the pop bookkeeping step
    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ($past(state_reg == S_IDLE && req_valid) || $past(state_reg == S_POP1)))
        else $error("heap count changed outside append or pop");

    // sift-down only runs on a nonempty heap
    a_sift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SL || state_reg == S_SR || state_reg == S_SC) |->
            (count_reg != '0))
        else $error("sift-down on an empty heap");

endmodule

// ----- tb/bmh_checker.sv -----
`timescale 1ns / 100ps
// checker for the binary min-heap engine: mirrors the heap from accepted request
// beats and compares each response beat in order; depends on bmh_pkg only
module bmh_checker
    import bmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   fail_count,
    output int   pending
);

    localparam logic [31:0] KEY_MASK =
        (KEY_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << KEY_BITS) - 64'd1);

    logic [31:0] mirror_store [CAPACITY];
    int unsigned mirror_count;
    rsp_t        heap_rsp_q [$];
    int          fails;

    function automatic void sift_down_from(input int unsigned start);
        int unsigned cur;
        int unsigned lft;
        int unsigned rgt;
        int unsigned pick;
        logic [31:0] tmp;
        cur = start;
        while (cur < mirror_count)
        begin
            lft = cur * 2 + 1;
            rgt = lft + 1;
            if (lft >= mirror_count)
                break;
            if (rgt < mirror_count)
                pick = (mirror_store[lft] < mirror_store[rgt]) ? lft : rgt;
            else
                pick = lft;
            if (mirror_store[cur] > mirror_store[pick])
            begin
                tmp                = mirror_store[pick];
                mirror_store[pick] = mirror_store[cur];
                mirror_store[cur]  = tmp;
                cur                = pick;
            end
            else
                break;
        end
    endfunction

    function automatic rsp_t apply_heap_op(input req_t beat);
        rsp_t        res;
        int unsigned idx;
        res.min_key = '0;
        res.status  = ST_OK;
        case (beat.opcode)
            OP_APPEND:
            begin
                if (mirror_count >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    mirror_store[mirror_count] = beat.key & KEY_MASK;
                    mirror_count++;
                end
            end
            OP_BUILD:
            begin
                idx = mirror_count;
                while (idx > 0)
                begin
                    idx--;
                    sift_down_from(idx);
                end
            end
            OP_POP:
            begin
                if (mirror_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.min_key = mirror_store[0];
                    mirror_count--;
                    if (mirror_count != 0)
                    begin
                        mirror_store[0] = mirror_store[mirror_count];
                        sift_down_from(0);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            mirror_count = 0;
            heap_rsp_q.delete();
            fails = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // response first: a beat accepted on this edge cannot answer itself
            if (rsp_valid && !rsp_stall)
            begin
                if (heap_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response beat: min_key %h status %0d",
                             $time, rsp.min_key, rsp.status);
                    fails++;
                end
                else
                begin
                    want = heap_rsp_q.pop_front();
                    if (rsp.min_key !== want.min_key)
                    begin
                        $display("%0t: min_key mismatch: expected %h actual %h",
                                 $time, want.min_key, rsp.min_key);
                        fails++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        fails++;
                    end
                end
            end
            if (req_valid && !req_stall)
                heap_rsp_q.push_back(apply_heap_op(req));
            fail_count <= fails;
            pending    <= heap_rsp_q.size();
        end
    end

endmodule

// ----- tb/tb_binary_min_heap_engine_top.sv -----
`timescale 1ns / 100ps
// testbench top for the binary min-heap engine: clock, reset, request stimulus,
// response back-pressure and verdict; depends on bmh_pkg, the engine and bmh_checker
module tb_binary_min_heap_engine_top
    import bmh_pkg::*;
();

    localparam int         CAPACITY         = CAPACITY_DEF;
    localparam int         KEY_BITS         = KEY_BITS_DEF;
    localparam int         CLK_PERIOD       = 12;
    localparam int         TIMEOUT_CYCLES   = 600000;
    localparam int         SMALL_BEATS      = 200;
    localparam int         TAIL_BEATS       = 60;
    localparam int         LONG_HOLD_CYCLES = 300;
    localparam logic [1:0] OP_UNUSED        = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending;

    int          idle_pct;
    bit          quiet_tail;
    logic        long_hold_go;
    int unsigned heap_len;
    int          sent;

    binary_min_heap_engine_top #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    bmh_checker #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_BITS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .fail_count(fail_count),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[binary_min_heap_engine_top] ERROR");
        $finish;
    end

    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 7));
            3:       return 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [31:0] k);
        req_t beat;
        beat.opcode = op;
        beat.key    = k;
        if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (op == OP_APPEND && heap_len < CAPACITY)
            heap_len++;
        else if (op == OP_POP && heap_len > 0)
            heap_len--;
        if (op != OP_UNUSED)
            sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // response side: random stall bursts plus one long hold on request
    initial
    begin
        int burst_left;
        int hold_left;
        bit hold_taken;
        burst_left = 0;
        hold_left  = 0;
        hold_taken = 0;
        rsp_stall  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (long_hold_go && !hold_taken)
            begin
                hold_taken = 1;
                hold_left  = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_tail && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                burst_left = $urandom_range(1, 5) - 1;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        int kind;
        int m;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        idle_pct     = 0;
        quiet_tail   = 0;
        long_hold_go = 1'b0;
        heap_len     = 0;
        sent         = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty heap, unused opcode, single entry
        send_beat(OP_POP, 32'hFFFF_FFFF);
        send_beat(OP_BUILD, $urandom());
        send_beat(OP_UNUSED, $urandom());
        send_beat(OP_APPEND, 32'hFFFF_FFFF);
        send_beat(OP_BUILD, 32'h0000_0000);
        send_beat(OP_POP, $urandom());
        // root with equal children, then a larger build and unordered append
        send_beat(OP_APPEND, 32'h0000_0009);
        send_beat(OP_APPEND, 32'h0000_0004);
        send_beat(OP_APPEND, 32'h0000_0004);
        send_beat(OP_BUILD, $urandom());
        send_beat(OP_APPEND, 32'h0000_0000);
        send_beat(OP_APPEND, 32'h8000_0000);
        send_beat(OP_APPEND, 32'hFFFF_FFFF);
        send_beat(OP_BUILD, $urandom());
        send_beat(OP_APPEND, 32'h0000_0002);
        repeat (7) send_beat(OP_POP, $urandom());
        wait_drained();

        // long response hold while requests keep coming
        long_hold_go <= 1'b1;
        repeat (12) send_beat(OP_APPEND, pick_key());
        long_hold_go <= 1'b0;
        repeat (13) send_beat(OP_POP, $urandom());
        wait_drained();

        // small heaps: mostly append, build, pop sequences
        while (sent < SMALL_BEATS)
        begin
            case ($urandom_range(0, 3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                repeat ($urandom_range(1, 15)) send_beat(OP_APPEND, pick_key());
                send_beat(OP_BUILD, $urandom());
                m = $urandom_range(0, heap_len + 1);
                repeat (m) send_beat(OP_POP, $urandom());
            end
            else if (kind < 9)
            begin
                repeat ($urandom_range(1, 8))
                    send_beat(2'($urandom_range(0, 3)), pick_key());
            end
            else
            begin
                send_beat(OP_BUILD, $urandom());
                send_beat(OP_BUILD, $urandom());
                repeat (heap_len + 1) send_beat(OP_POP, $urandom());
                wait_drained();
            end
            if (heap_len > 40)
                repeat (heap_len - 20) send_beat(OP_POP, $urandom());
        end
        wait_drained();

        // fill the store, overflow it, build it and work near full
        idle_pct = 20;
        while (heap_len < CAPACITY)
            send_beat(OP_APPEND, pick_key());
        repeat (3) send_beat(OP_APPEND, pick_key());
        send_beat(OP_BUILD, $urandom());
        repeat (TAIL_BEATS)
            send_beat(($urandom_range(0, 9) < 7) ? OP_POP : OP_APPEND, pick_key());
        quiet_tail = 1'b1;
        repeat (TAIL_BEATS)
            send_beat(($urandom_range(0, 9) < 7) ? OP_POP : OP_APPEND, pick_key());

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[binary_min_heap_engine_top] OK");
        else
            $display("[binary_min_heap_engine_top] ERROR");
        $finish;
    end

endmodule
